// ===== rtl/core/mnms_pkg.sv =====
package mnms_pkg;

    localparam int MAX_BOXES_DEF  = 1024;
    localparam int MAX_KEEP_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam logic [2:0] CFG_SCORE_FLOOR  = 3'd0;
    localparam logic [2:0] CFG_KEEP_FLOOR   = 3'd1;
    localparam logic [2:0] CFG_GAUSS_FACTOR = 3'd2;
    localparam logic [2:0] CFG_RANK_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_COORDS_NORM  = 3'd4;
    localparam logic [2:0] CFG_GAUSS_MODE   = 3'd5;

    // exp(-2^(b-12)) for table index b, in Q0.32
    localparam logic [31:0] EXP_NEG_POW2 [16] = '{
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380100, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
    };

    typedef enum logic [5:0] {
        ST_LOAD,
        ST_RK_SCAN,
        ST_RK_TAIL,
        ST_RK_DEC,
        ST_IO_START,
        ST_IA_RANK,
        ST_IA_BOX,
        ST_IA_LATCH,
        ST_JB_RANK,
        ST_JB_BOX,
        ST_JB_LATCH,
        ST_GEO,
        ST_MUL_I,
        ST_MUL_A,
        ST_MUL_B,
        ST_UNI,
        ST_DIV_IOU,
        ST_IOU_WR,
        ST_DC_INIT,
        ST_DC_RANK,
        ST_DC_SCORE,
        ST_DC_RD,
        ST_DC_SEL,
        ST_DIV_DEC,
        ST_GS_SQI,
        ST_GS_SQP,
        ST_GS_SCL,
        ST_GS_EXP,
        ST_GS_RND,
        ST_DC_MIN,
        ST_DC_FIN,
        ST_DC_EMIT,
        ST_END
    } state_t;

endpackage

// ===== rtl/core/matrix_nms_single_class_unit.sv =====
// Matrix NMS for one class with soft (linear or gaussian) score decay.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, writes are meant for idle time between sets.
// Input stream: one box per beat, one beat per cycle while loading; s_tlast
// marks the last box and starts the set. s_tready is low until the whole set
// has been worked off and the last result has entered the output register.
// Processing after the last box, n loaded and k ranked boxes:
//   ranking: up to k+1 scans over the n entries of the score memory
//   IoU: box reads per ranked row and per pair, products on a shared
//   multiplier, then a 16-step restoring divider
//   decay: per box and per pair, the same divider for linear decay,
//   a 16-step exp table product for gaussian decay
// Results leave in rank order on m_*; m_tlast marks the last one, m_tuser
// flags a set where no box survived (single beat, zero data).
// A stalled receiver holds the output register; the sequencer waits when a
// second result is ready, and loading of the next set may start meanwhile.
// Reset (rst_n low, asynchronous) returns to loading with an empty set and
// the register reset values; the box and score memories are not cleared.
module matrix_nms_single_class_unit #(
    parameter int MAX_BOXES  = mnms_pkg::MAX_BOXES_DEF,
    parameter int MAX_KEEP   = mnms_pkg::MAX_KEEP_DEF,
    parameter int COORD_BITS = mnms_pkg::COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // box_score, left_edge, top_edge, right_edge, bottom_edge
    input  logic [79:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // box_index, decayed_score, zero fill
    output logic [31:0] m_tdata,
    // none_kept
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);
    import mnms_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int IW    = $clog2(MAX_BOXES);
    localparam int LCW   = $clog2(MAX_BOXES + 1);
    localparam int KW    = $clog2(MAX_KEEP + 1);
    localparam int KAW   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int PAIRS = (MAX_KEEP * (MAX_KEEP - 1)) / 2;
    localparam int PD    = (PAIRS > 0) ? PAIRS : 1;
    localparam int PAW   = (PD > 1) ? $clog2(PD) : 1;
    localparam int GW    = CW + 2;
    localparam int PW    = 2 * GW;
    localparam int UW    = PW + 2;
    localparam int DW    = UW;
    localparam int SW    = (GW > 32) ? GW + 1 : 33;
    localparam int RW    = 16 + IW;

    function automatic logic signed [GW-1:0] gx(input logic [CW-1:0] v);
        return {{2{v[CW-1]}}, v};
    endfunction

    function automatic logic signed [SW-1:0] sx(input logic signed [GW-1:0] v);
        return {{(SW-GW){v[GW-1]}}, v};
    endfunction

    state_t state_reg, state_next;

    logic [15:0] score_floor_reg, keep_floor_reg, gauss_factor_reg;
    logic [6:0]  rank_limit_reg;
    logic        coords_norm_reg, gauss_mode_reg;

    logic [LCW-1:0] load_cnt_reg, n_reg, n_in;
    logic [IW-1:0]  scan_i_reg, rd_i_reg, best_i_reg, prev_i_reg;
    logic           rd_valid_reg, found_reg, have_prev_reg;
    logic [15:0]    best_s_reg, prev_s_reg;
    logic [KW-1:0]  count_reg, i_reg, j_reg, lim;
    logic [PAW-1:0] pair_reg;
    logic [3:0]     div_cnt_reg, bit_reg;
    logic           acc_one_reg;
    logic           held_valid_reg;
    logic           m_tvalid_reg;

    logic [15:0]    score_mem [MAX_BOXES];
    logic [4*CW-1:0] box_mem  [MAX_BOXES];
    logic [RW-1:0]  rank_mem  [MAX_KEEP];
    logic [15:0]    iou_mem   [PD];
    logic [15:0]    peak_mem  [MAX_KEEP];
    logic [15:0]    score_rd, iou_rd, peak_rd;
    logic [4*CW-1:0] box_rd;
    logic [RW-1:0]  rank_rd;

    logic [4*CW-1:0] box_a_reg, box_b_reg;
    logic signed [GW-1:0] iw_reg, ih_reg, aw_reg, ah_reg, bw_reg, bh_reg;
    logic           disj_reg, ainv_reg, binv_reg;
    logic signed [PW-1:0] inter_reg, area_a_reg, area_b_reg;
    logic [15:0]    iou_q_reg, peak_acc_reg, iou_v_reg, peak_v_reg;
    logic [DW-1:0]  div_r_reg, div_d_reg;
    logic [15:0]    div_q_reg;
    logic [16:0]    cand_reg, md_reg;
    logic [15:0]    sc_reg, ds_reg;
    logic [IW-1:0]  ix_reg;
    logic [31:0]    sq_reg, d_reg, acc_reg;
    logic [15:0]    y_reg;
    logic [IW-1:0]  held_idx_reg;
    logic [15:0]    held_score_reg;
    logic [9:0]     out_idx_reg;
    logic [15:0]    out_score_reg;
    logic           out_none_reg, out_last_reg;

    logic           s_acc, load_we, cand_ok, out_free, push, keep, emit_go;
    logic           rank_we, iou_we, peak_we, last_j, last_i;
    logic [KAW-1:0] rank_raddr, peak_waddr;
    logic [15:0]    peak_wdata, peak_new;
    logic signed [SW-1:0] mul_a, mul_b;
    logic signed [2*SW-1:0] mul_p;
    logic [DW:0]    div_r2;
    logic           div_ge;
    logic [DW-1:0]  div_r_next;
    logic [15:0]    div_q_next;
    logic [16:0]    lin_num, lin_den;
    logic [63:0]    exp_sum;
    logic [32:0]    rnd_sum;
    logic signed [UW-1:0] uni_s, inter_s;
    logic [31:0]    idx_w;

    logic signed [GW-1:0] a0, a1, a2, a3, b0, b1, b2, b3, pad_g;
    logic signed [GW-1:0] lx, ly, hx, hy;

    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign load_we   = s_acc && (32'(load_cnt_reg) < MAX_BOXES);
    assign n_in      = load_cnt_reg + LCW'(load_we);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign lim = (rank_limit_reg == 7'd0 || 32'(rank_limit_reg) > MAX_KEEP)
               ? KW'(MAX_KEEP) : KW'(rank_limit_reg);

    assign cand_ok = rd_valid_reg && (score_rd > score_floor_reg)
                   && (!have_prev_reg || score_rd < prev_s_reg
                       || (score_rd == prev_s_reg && rd_i_reg > prev_i_reg))
                   && (!found_reg || score_rd > best_s_reg);

    assign last_j  = (j_reg + KW'(1)) == i_reg;
    assign last_i  = (i_reg + KW'(1)) == count_reg;
    assign keep    = ds_reg > keep_floor_reg;
    assign emit_go = !(keep && held_valid_reg && !out_free);
    assign peak_new = (iou_q_reg > peak_acc_reg) ? iou_q_reg : peak_acc_reg;

    assign mul_p = mul_a * mul_b;

    assign div_r2     = {div_r_reg, 1'b0};
    assign div_ge     = div_r2 >= {1'b0, div_d_reg};
    assign div_r_next = div_ge ? DW'(div_r2 - {1'b0, div_d_reg}) : DW'(div_r2);
    assign div_q_next = {div_q_reg[14:0], div_ge};

    assign lin_num = 17'h10000 - {1'b0, iou_rd};
    assign lin_den = 17'h10000 - {1'b0, peak_rd};
    assign exp_sum = mul_p[63:0] + 64'h8000_0000;
    assign rnd_sum = {1'b0, acc_reg} + 33'h0_0000_8000;

    assign a0 = gx(box_a_reg[0*CW +: CW]);
    assign a1 = gx(box_a_reg[1*CW +: CW]);
    assign a2 = gx(box_a_reg[2*CW +: CW]);
    assign a3 = gx(box_a_reg[3*CW +: CW]);
    assign b0 = gx(box_b_reg[0*CW +: CW]);
    assign b1 = gx(box_b_reg[1*CW +: CW]);
    assign b2 = gx(box_b_reg[2*CW +: CW]);
    assign b3 = gx(box_b_reg[3*CW +: CW]);
    assign pad_g = GW'(!coords_norm_reg);
    assign lx = (a0 > b0) ? a0 : b0;
    assign ly = (a1 > b1) ? a1 : b1;
    assign hx = (a2 < b2) ? a2 : b2;
    assign hy = (a3 < b3) ? a3 : b3;

    assign inter_s = UW'(inter_reg);
    assign uni_s   = UW'(area_a_reg) + UW'(area_b_reg) - inter_s;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:     if (s_acc && s_tlast) state_next = ST_RK_SCAN;
            ST_RK_SCAN:  if ((LCW'(scan_i_reg) + LCW'(1)) == n_reg) state_next = ST_RK_TAIL;
            ST_RK_TAIL:  state_next = ST_RK_DEC;
            ST_RK_DEC:
            begin
                if (found_reg && (count_reg + KW'(1)) != lim)
                    state_next = ST_RK_SCAN;
                else
                    state_next = ST_IO_START;
            end
            ST_IO_START:
            begin
                if (count_reg == '0)
                    state_next = ST_END;
                else if (count_reg == KW'(1))
                    state_next = ST_DC_INIT;
                else
                    state_next = ST_IA_RANK;
            end
            ST_IA_RANK:  state_next = ST_IA_BOX;
            ST_IA_BOX:   state_next = ST_IA_LATCH;
            ST_IA_LATCH: state_next = ST_JB_RANK;
            ST_JB_RANK:  state_next = ST_JB_BOX;
            ST_JB_BOX:   state_next = ST_JB_LATCH;
            ST_JB_LATCH: state_next = ST_GEO;
            ST_GEO:      state_next = ST_MUL_I;
            ST_MUL_I:    state_next = ST_MUL_A;
            ST_MUL_A:    state_next = ST_MUL_B;
            ST_MUL_B:    state_next = ST_UNI;
            ST_UNI:
            begin
                if (disj_reg || inter_reg <= 0 || uni_s <= 0 || inter_s >= uni_s)
                    state_next = ST_IOU_WR;
                else
                    state_next = ST_DIV_IOU;
            end
            ST_DIV_IOU:  if (div_cnt_reg == 4'd15) state_next = ST_IOU_WR;
            ST_IOU_WR:
            begin
                if (!last_j)
                    state_next = ST_JB_RANK;
                else if (last_i)
                    state_next = ST_DC_INIT;
                else
                    state_next = ST_IA_RANK;
            end
            ST_DC_INIT:  state_next = ST_DC_RANK;
            ST_DC_RANK:  state_next = ST_DC_SCORE;
            ST_DC_SCORE: state_next = (i_reg == '0) ? ST_DC_FIN : ST_DC_RD;
            ST_DC_RD:    state_next = ST_DC_SEL;
            ST_DC_SEL:
            begin
                if (gauss_mode_reg)
                    state_next = (iou_rd <= peak_rd) ? ST_DC_MIN : ST_GS_SQI;
                else
                    state_next = (lin_num >= lin_den) ? ST_DC_MIN : ST_DIV_DEC;
            end
            ST_DIV_DEC:  if (div_cnt_reg == 4'd15) state_next = ST_DC_MIN;
            ST_GS_SQI:   state_next = ST_GS_SQP;
            ST_GS_SQP:   state_next = ST_GS_SCL;
            ST_GS_SCL:   state_next = (mul_p[47:44] != 4'd0) ? ST_DC_MIN : ST_GS_EXP;
            ST_GS_EXP:   if (bit_reg == 4'd15) state_next = ST_GS_RND;
            ST_GS_RND:   state_next = ST_DC_MIN;
            ST_DC_MIN:   state_next = last_j ? ST_DC_FIN : ST_DC_RD;
            ST_DC_FIN:   state_next = ST_DC_EMIT;
            ST_DC_EMIT:
            begin
                if (emit_go)
                    state_next = last_i ? ST_END : ST_DC_RANK;
            end
            ST_END:      if (out_free) state_next = ST_LOAD;
            default:     state_next = ST_LOAD;
        endcase
    end

    // control outputs, memory ports and multiplier operands
    always_comb
    begin
        s_tready   = 1'b0;
        rank_we    = 1'b0;
        iou_we     = 1'b0;
        peak_we    = 1'b0;
        peak_waddr = i_reg[KAW-1:0];
        peak_wdata = peak_new;
        push       = 1'b0;
        rank_raddr = i_reg[KAW-1:0];
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_LOAD:     s_tready = 1'b1;
            ST_RK_DEC:   rank_we = found_reg;
            ST_IO_START:
            begin
                peak_we    = count_reg != '0;
                peak_waddr = '0;
                peak_wdata = '0;
            end
            ST_JB_RANK:  rank_raddr = j_reg[KAW-1:0];
            ST_MUL_I:
            begin
                mul_a = sx(iw_reg);
                mul_b = sx(ih_reg);
            end
            ST_MUL_A:
            begin
                mul_a = sx(aw_reg);
                mul_b = sx(ah_reg);
            end
            ST_MUL_B:
            begin
                mul_a = sx(bw_reg);
                mul_b = sx(bh_reg);
            end
            ST_IOU_WR:
            begin
                iou_we  = 1'b1;
                peak_we = last_j;
            end
            ST_GS_SQI:
            begin
                mul_a = SW'(iou_v_reg);
                mul_b = SW'(iou_v_reg);
            end
            ST_GS_SQP:
            begin
                mul_a = SW'(peak_v_reg);
                mul_b = SW'(peak_v_reg);
            end
            ST_GS_SCL:
            begin
                mul_a = SW'(d_reg);
                mul_b = SW'(gauss_factor_reg);
            end
            ST_GS_EXP:
            begin
                mul_a = SW'(acc_reg);
                mul_b = SW'(EXP_NEG_POW2[bit_reg]);
            end
            ST_DC_FIN:
            begin
                mul_a = SW'(md_reg);
                mul_b = SW'(sc_reg);
            end
            ST_DC_EMIT:  push = keep && held_valid_reg && out_free;
            ST_END:      push = out_free;
            default:     s_tready = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            score_mem[load_cnt_reg[IW-1:0]] <= s_tdata[15:0];
        end
        score_rd <= score_mem[scan_i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            box_mem[load_cnt_reg[IW-1:0]] <= {
                CW'({16'd0, s_tdata[79:64]}), CW'({16'd0, s_tdata[63:48]}),
                CW'({16'd0, s_tdata[47:32]}), CW'({16'd0, s_tdata[31:16]})};
        end
        box_rd <= box_mem[rank_rd[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[count_reg[KAW-1:0]] <= {best_s_reg, best_i_reg};
        end
        rank_rd <= rank_mem[rank_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (iou_we)
        begin
            iou_mem[pair_reg] <= iou_q_reg;
        end
        iou_rd <= iou_mem[pair_reg];
    end

    always_ff @(posedge clk)
    begin
        if (peak_we)
        begin
            peak_mem[peak_waddr] <= peak_wdata;
        end
        peak_rd <= peak_mem[j_reg[KAW-1:0]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            score_floor_reg  <= 16'd0;
            keep_floor_reg   <= 16'd0;
            gauss_factor_reg <= 16'd512;
            rank_limit_reg   <= 7'd64;
            coords_norm_reg  <= 1'b1;
            gauss_mode_reg   <= 1'b0;
            load_cnt_reg     <= '0;
            n_reg            <= '0;
            scan_i_reg       <= '0;
            rd_valid_reg     <= 1'b0;
            found_reg        <= 1'b0;
            have_prev_reg    <= 1'b0;
            count_reg        <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            pair_reg         <= '0;
            div_cnt_reg      <= '0;
            bit_reg          <= '0;
            acc_one_reg      <= 1'b0;
            held_valid_reg   <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCORE_FLOOR:  score_floor_reg  <= cfg_data;
                    CFG_KEEP_FLOOR:   keep_floor_reg   <= cfg_data;
                    CFG_GAUSS_FACTOR: gauss_factor_reg <= cfg_data;
                    CFG_RANK_LIMIT:   rank_limit_reg   <= cfg_data[6:0];
                    CFG_COORDS_NORM:  coords_norm_reg  <= cfg_data[0];
                    CFG_GAUSS_MODE:   gauss_mode_reg   <= cfg_data[0];
                    default:          rank_limit_reg   <= rank_limit_reg;
                endcase
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (s_acc)
                    begin
                        if (s_tlast)
                        begin
                            load_cnt_reg  <= '0;
                            n_reg         <= n_in;
                            count_reg     <= '0;
                            have_prev_reg <= 1'b0;
                            found_reg     <= 1'b0;
                            scan_i_reg    <= '0;
                            rd_valid_reg  <= 1'b0;
                        end
                        else
                        begin
                            load_cnt_reg <= n_in;
                        end
                    end
                end
                ST_RK_SCAN:
                begin
                    rd_valid_reg <= 1'b1;
                    scan_i_reg   <= scan_i_reg + IW'(1);
                    if (cand_ok)
                        found_reg <= 1'b1;
                end
                ST_RK_TAIL:
                begin
                    rd_valid_reg <= 1'b0;
                    if (cand_ok)
                        found_reg <= 1'b1;
                end
                ST_RK_DEC:
                begin
                    found_reg  <= 1'b0;
                    scan_i_reg <= '0;
                    if (found_reg)
                    begin
                        have_prev_reg <= 1'b1;
                        count_reg     <= count_reg + KW'(1);
                    end
                end
                ST_IO_START:
                begin
                    i_reg    <= KW'(1);
                    pair_reg <= '0;
                end
                ST_IA_LATCH: j_reg <= '0;
                ST_UNI:      div_cnt_reg <= '0;
                ST_DIV_IOU:  div_cnt_reg <= div_cnt_reg + 4'd1;
                ST_IOU_WR:
                begin
                    pair_reg <= pair_reg + PAW'(1);
                    j_reg    <= j_reg + KW'(1);
                    if (last_j)
                        i_reg <= i_reg + KW'(1);
                end
                ST_DC_INIT:
                begin
                    i_reg    <= '0;
                    pair_reg <= '0;
                end
                ST_DC_RANK:  j_reg <= '0;
                ST_DC_SEL:   div_cnt_reg <= '0;
                ST_DIV_DEC:  div_cnt_reg <= div_cnt_reg + 4'd1;
                ST_GS_SCL:
                begin
                    bit_reg     <= '0;
                    acc_one_reg <= 1'b1;
                end
                ST_GS_EXP:
                begin
                    bit_reg <= bit_reg + 4'd1;
                    if (y_reg[bit_reg])
                        acc_one_reg <= 1'b0;
                end
                ST_DC_MIN:
                begin
                    pair_reg <= pair_reg + PAW'(1);
                    j_reg    <= j_reg + KW'(1);
                end
                ST_DC_EMIT:
                begin
                    if (emit_go)
                    begin
                        i_reg <= i_reg + KW'(1);
                        if (keep)
                            held_valid_reg <= 1'b1;
                    end
                end
                ST_END:      if (out_free) held_valid_reg <= 1'b0;
                default:     n_reg <= n_reg;
            endcase
            if (push)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign idx_w = 32'(held_idx_reg);

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_RK_SCAN:
            begin
                rd_i_reg <= scan_i_reg;
                if (cand_ok)
                begin
                    best_s_reg <= score_rd;
                    best_i_reg <= rd_i_reg;
                end
            end
            ST_RK_TAIL:
            begin
                if (cand_ok)
                begin
                    best_s_reg <= score_rd;
                    best_i_reg <= rd_i_reg;
                end
            end
            ST_RK_DEC:
            begin
                prev_s_reg <= best_s_reg;
                prev_i_reg <= best_i_reg;
            end
            ST_IA_LATCH:
            begin
                box_a_reg    <= box_rd;
                peak_acc_reg <= '0;
            end
            ST_JB_LATCH: box_b_reg <= box_rd;
            ST_GEO:
            begin
                disj_reg <= (b0 > a2) || (b2 < a0) || (b1 > a3) || (b3 < a1);
                ainv_reg <= (a2 < a0) || (a3 < a1);
                binv_reg <= (b2 < b0) || (b3 < b1);
                iw_reg   <= hx - lx + pad_g;
                ih_reg   <= hy - ly + pad_g;
                aw_reg   <= a2 - a0 + pad_g;
                ah_reg   <= a3 - a1 + pad_g;
                bw_reg   <= b2 - b0 + pad_g;
                bh_reg   <= b3 - b1 + pad_g;
            end
            ST_MUL_I:    inter_reg  <= disj_reg ? '0 : mul_p[PW-1:0];
            ST_MUL_A:    area_a_reg <= ainv_reg ? '0 : mul_p[PW-1:0];
            ST_MUL_B:    area_b_reg <= binv_reg ? '0 : mul_p[PW-1:0];
            ST_UNI:
            begin
                if (disj_reg || inter_reg <= 0 || uni_s <= 0)
                    iou_q_reg <= 16'd0;
                else
                    iou_q_reg <= 16'hFFFF;
                div_r_reg <= DW'(inter_s);
                div_d_reg <= DW'(uni_s);
            end
            ST_DIV_IOU:
            begin
                div_r_reg <= div_r_next;
                div_q_reg <= div_q_next;
                if (div_cnt_reg == 4'd15)
                    iou_q_reg <= div_q_next;
            end
            ST_IOU_WR:   peak_acc_reg <= peak_new;
            ST_DC_RANK:  md_reg <= 17'h10000;
            ST_DC_SCORE:
            begin
                sc_reg <= rank_rd[RW-1:IW];
                ix_reg <= rank_rd[IW-1:0];
            end
            ST_DC_SEL:
            begin
                iou_v_reg  <= iou_rd;
                peak_v_reg <= peak_rd;
                cand_reg   <= 17'h10000;
                div_r_reg  <= DW'(lin_num);
                div_d_reg  <= DW'(lin_den);
            end
            ST_DIV_DEC:
            begin
                div_r_reg <= div_r_next;
                div_q_reg <= div_q_next;
                if (div_cnt_reg == 4'd15)
                    cand_reg <= {1'b0, div_q_next};
            end
            ST_GS_SQI:   sq_reg <= mul_p[31:0];
            ST_GS_SQP:   d_reg <= sq_reg - mul_p[31:0];
            ST_GS_SCL:
            begin
                y_reg    <= mul_p[43:28];
                cand_reg <= '0;
            end
            ST_GS_EXP:
            begin
                if (y_reg[bit_reg])
                    acc_reg <= acc_one_reg ? EXP_NEG_POW2[bit_reg] : exp_sum[63:32];
            end
            ST_GS_RND:   cand_reg <= acc_one_reg ? 17'h10000 : rnd_sum[32:16];
            ST_DC_MIN:   if (cand_reg < md_reg) md_reg <= cand_reg;
            ST_DC_FIN:   ds_reg <= mul_p[31:16];
            ST_DC_EMIT:
            begin
                if (emit_go && keep)
                begin
                    held_idx_reg   <= ix_reg;
                    held_score_reg <= ds_reg;
                end
            end
            default:     sq_reg <= sq_reg;
        endcase
        if (push)
        begin
            if (state_reg == ST_END && !held_valid_reg)
            begin
                out_idx_reg   <= '0;
                out_score_reg <= '0;
                out_none_reg  <= 1'b1;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_idx_reg   <= idx_w[9:0];
                out_score_reg <= held_score_reg;
                out_none_reg  <= 1'b0;
                out_last_reg  <= state_reg == ST_END;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_score_reg, out_idx_reg};
    assign m_tuser  = out_none_reg;
    assign m_tlast  = out_last_reg;

    a_none_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == 32'd0))
        else $error("none-kept beat carries data or lacks last");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(load_cnt_reg) <= MAX_BOXES)
        else $error("load count beyond store depth");

    a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (state_reg != ST_LOAD))
        else $error("pending result left behind at set end");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RK_DEC) |-> (32'(count_reg) < MAX_KEEP))
        else $error("rank write beyond rank list");

endmodule
